// ===== src/assert_macros.svh =====
// assertion macros shared by the brush core rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/ghb_pkg.sv =====
// package of the gaussian heightmap brush: widths, op codes, weight constants
// used by the interfaces and by every module of the block except ghb_ram
package ghb_pkg;

    localparam int ROWS_DEF   = 64;
    localparam int COLS_DEF   = 64;
    localparam int RADIUS_DEF = 21;

    localparam int OP_W   = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int H_W    = 16;
    localparam int MAXH_W = 14;
    localparam int W_W    = 17;

    // radius is at most 63: offsets fit 7 bits signed, squared distance 13 bits
    localparam int DR_W = 7;
    localparam int D2_W = 13;

    localparam logic [MAXH_W-1:0] MAXH_RESET = 14'd4096;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;
    localparam logic [OP_W-1:0] OP_DELTA = 2'd3;

    // exp(-1/98) in q0.32, and unity weight in q1.16
    localparam logic [31:0]    QSTEP = 32'd4251363944;
    localparam logic [W_W-1:0] WONE  = 17'h10000;

    typedef struct packed {
        logic signed [H_W-1:0] tgt;
        logic                  up;
        logic [15:0]           s;
    } t_brush_ctl;

endpackage

// ===== src/ghb_in_if.sv =====
// input channel of the brush core: op, cell position and value
// depends on ghb_pkg
interface ghb_in_if;
    logic                               valid;
    logic                               ready;
    logic [ghb_pkg::OP_W-1:0]           op;
    logic [ghb_pkg::ROW_W-1:0]          row;
    logic [ghb_pkg::COL_W-1:0]          column;
    logic signed [ghb_pkg::H_W-1:0]     value;

    modport source (output valid, op, row, column, value, input ready);
    modport sink (input valid, op, row, column, value, output ready);
endinterface

// ===== src/ghb_out_if.sv =====
// result channel of the brush core: one height word per op
// depends on ghb_pkg
interface ghb_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [ghb_pkg::H_W-1:0] height;

    modport source (output valid, height, input ready);
    modport sink (input valid, height, output ready);
endinterface

// ===== src/ghb_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module ghb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ghb_weight.sv =====
// gaussian weight table in ram, filled after reset by the exp recurrence
// depends on ghb_pkg and ghb_ram
module ghb_weight #(
    parameter int RADIUS_CELLS = ghb_pkg::RADIUS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [((RADIUS_CELLS*RADIUS_CELLS+1) > 1 ?
                   $clog2(RADIUS_CELLS*RADIUS_CELLS+1) : 1)-1:0] i_raddr,
    output logic [ghb_pkg::W_W-1:0] o_rdata,
    output logic o_ready
);

    localparam int WSIZE = RADIUS_CELLS * RADIUS_CELLS + 1;
    localparam int WAW   = (WSIZE > 1) ? $clog2(WSIZE) : 1;
    localparam int IW    = $clog2(WSIZE + 1);

    logic [IW-1:0]            r_idx;
    logic                     r_phase;
    logic                     r_ready;
    logic [31:0]              r_acc;
    logic [63:0]              r_prod;
    logic                     w_we;
    logic [ghb_pkg::W_W-1:0]  w_wdata;

    // entry zero is exactly one; later entries round the q0.32 accumulator
    assign w_we    = !r_ready && !r_phase;
    assign w_wdata = (r_idx == '0) ? ghb_pkg::WONE
                   : ghb_pkg::W_W'((33'(r_acc) + 33'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= 1'b0;
            r_ready <= 1'b0;
        end else if (!r_ready) begin
            if (!r_phase) begin
                r_prod  <= 64'(r_acc) * 64'(ghb_pkg::QSTEP);
                r_phase <= 1'b1;
            end else begin
                r_acc   <= (r_idx == '0) ? ghb_pkg::QSTEP
                         : 32'((r_prod + 64'h8000_0000) >> 32);
                r_phase <= 1'b0;
                r_idx   <= r_idx + 1'b1;
                if (r_idx == IW'(WSIZE - 1)) begin
                    r_ready <= 1'b1;
                end
            end
        end
    end

    ghb_ram #(
        .WIDTH (ghb_pkg::W_W),
        .DEPTH (WSIZE)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[WAW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

    assign o_ready = r_ready;

endmodule

// ===== src/ghb_cell_update.sv =====
// per cell brush datapath: offset product, new height, direction test
// depends on ghb_pkg; fed by the registered reads of both rams
module ghb_cell_update #(
    parameter int AW = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [AW-1:0]                    i_addr,
    input  logic signed [ghb_pkg::H_W-1:0]   i_cur,
    input  logic [ghb_pkg::W_W-1:0]          i_w,
    input  ghb_pkg::t_brush_ctl              i_ctl,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic [ghb_pkg::H_W-1:0]          o_wdata,
    output logic                             o_busy
);

    logic                            r_a_valid;
    logic [AW-1:0]                   r_a_addr;
    logic signed [ghb_pkg::H_W-1:0]  r_a_cur;
    logic [31:0]                     r_a_prod;
    logic                            r_b_valid;
    logic [AW-1:0]                   r_b_addr;
    logic signed [ghb_pkg::H_W-1:0]  r_b_cur;
    logic signed [17:0]              r_b_nh;

    logic [32:0]                     n_prod;
    logic [16:0]                     n_off;
    logic signed [17:0]              n_nh;
    logic signed [17:0]              w_tgt_x;
    logic signed [17:0]              w_off_x;
    logic signed [17:0]              w_cur_x;

    assign n_prod  = 33'(i_ctl.s) * 33'(ghb_pkg::WONE - i_w);
    assign n_off   = 17'((33'(r_a_prod) + 33'd32768) >> 16);
    assign w_tgt_x = 18'(i_ctl.tgt);
    assign w_off_x = signed'({1'b0, n_off});
    assign n_nh    = i_ctl.up ? (w_tgt_x - w_off_x) : (w_tgt_x + w_off_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_a_addr <= i_addr;
        r_a_cur  <= i_cur;
        r_a_prod <= n_prod[31:0];
        r_b_addr <= r_a_addr;
        r_b_cur  <= r_a_cur;
        r_b_nh   <= n_nh;
    end

    // a cell only ever moves toward the brush direction
    assign w_cur_x = 18'(r_b_cur);
    assign o_we    = r_b_valid && ((r_b_nh > w_cur_x) == i_ctl.up);
    assign o_waddr = r_b_addr;
    assign o_wdata = r_b_nh[ghb_pkg::H_W-1:0];
    assign o_busy  = r_a_valid || r_b_valid;

endmodule

// ===== src/gaussian_heightmap_brush_core.sv =====
// top of the gaussian heightmap brush: control, scan, height ram, result register
// depends on ghb_pkg, ghb_in_if, ghb_out_if, ghb_ram, ghb_weight, ghb_cell_update, assert_macros.svh
// reset: a clearing pass zeroes every height cell and waits for the weight table fill; no words taken
// write, out of range: idle, then done; read: idle, center, then done
// brush: idle, center, scan of the clipped square at one cell per cycle, drain until the cells
// scanned are written back, then done; a full stamp scans a 43 by 43 square
module gaussian_heightmap_brush_core #(
    parameter int ROWS         = ghb_pkg::ROWS_DEF,
    parameter int COLS         = ghb_pkg::COLS_DEF,
    parameter int RADIUS_CELLS = ghb_pkg::RADIUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ghb_pkg::MAXH_W-1:0]  i_cfg_data,
    ghb_in_if.sink                      i_in,
    ghb_out_if.source                   o_out
);

    `include "assert_macros.svh"

    localparam int DEPTH = ROWS * COLS;
    localparam int HAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CLR_W = $clog2(DEPTH + 1);
    localparam int CW    = (ROWS > 64) ? $clog2(ROWS) : 6;
    localparam int KW    = (COLS > 64) ? $clog2(COLS) : 6;
    localparam int WSIZE = RADIUS_CELLS * RADIUS_CELLS + 1;
    localparam int WAW   = (WSIZE > 1) ? $clog2(WSIZE) : 1;
    localparam int R2    = RADIUS_CELLS * RADIUS_CELLS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CENTER,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic [CLR_W-1:0]                   r_clr;
    logic [ghb_pkg::MAXH_W-1:0]         r_max_height;
    logic [ghb_pkg::OP_W-1:0]           r_op;
    logic [ghb_pkg::ROW_W-1:0]          r_row;
    logic [ghb_pkg::COL_W-1:0]          r_col;
    logic signed [ghb_pkg::H_W-1:0]     r_val;
    logic signed [ghb_pkg::H_W-1:0]     r_res;
    ghb_pkg::t_brush_ctl                r_ctl;
    logic [CW-1:0]                      r_r;
    logic [CW-1:0]                      r_r1;
    logic [KW-1:0]                      r_c;
    logic [KW-1:0]                      r_c0;
    logic [KW-1:0]                      r_c1;
    logic                               r_p1_valid;
    logic [HAW-1:0]                     r_p1_addr;
    logic                               r_out_valid;
    logic signed [ghb_pkg::H_W-1:0]     r_out_height;

    logic                               in_fire;
    logic                               in_bounds;
    logic [HAW-1:0]                     in_addr;
    logic [HAW-1:0]                     scan_addr;
    logic signed [ghb_pkg::DR_W-1:0]    dr;
    logic signed [ghb_pkg::DR_W-1:0]    dc;
    logic signed [ghb_pkg::D2_W:0]      dr_x;
    logic signed [ghb_pkg::D2_W:0]      dc_x;
    logic [ghb_pkg::D2_W-1:0]           d2;
    logic                               in_circle;

    logic signed [ghb_pkg::H_W-1:0]     h_rdata;
    logic [ghb_pkg::H_W-1:0]            h_rdata_u;
    logic                               h_we;
    logic [HAW-1:0]                     h_waddr;
    logic [ghb_pkg::H_W-1:0]            h_wdata;
    logic [HAW-1:0]                     h_raddr;
    logic [ghb_pkg::W_W-1:0]            w_rdata;
    logic                               w_ready;

    logic                               cell_we;
    logic [HAW-1:0]                     cell_waddr;
    logic [ghb_pkg::H_W-1:0]            cell_wdata;
    logic                               cell_busy;

    logic signed [16:0]                 n_sum;
    logic signed [16:0]                 n_m;
    logic signed [16:0]                 n_clamp;
    logic signed [ghb_pkg::H_W-1:0]     n_tgt;
    logic                               n_up;
    logic [15:0]                        n_s;
    logic [CW-1:0]                      n_r0;
    logic [CW-1:0]                      n_r1;
    logic [KW-1:0]                      n_c0;
    logic [KW-1:0]                      n_c1;

    assign in_fire   = i_in.valid && i_in.ready;
    assign in_bounds = (int'(i_in.row) < ROWS) && (int'(i_in.column) < COLS);
    assign in_addr   = HAW'(int'(i_in.row) * COLS + int'(i_in.column));
    assign scan_addr = HAW'(int'(r_r) * COLS + int'(r_c));

    // squared grid distance of the scanned cell from the brush center
    assign dr        = ghb_pkg::DR_W'(int'(r_r) - int'(r_row));
    assign dc        = ghb_pkg::DR_W'(int'(r_c) - int'(r_col));
    assign dr_x      = (ghb_pkg::D2_W+1)'(dr);
    assign dc_x      = (ghb_pkg::D2_W+1)'(dc);
    assign d2        = ghb_pkg::D2_W'(dr_x * dr_x + dc_x * dc_x);
    assign in_circle = (d2 <= ghb_pkg::D2_W'(R2));

    assign h_rdata   = signed'(h_rdata_u);
    assign h_raddr   = (r_state == S_SCAN) ? scan_addr : in_addr;

    // target and direction from the center height, brush scale from the max height, clipped scan square
    always_comb begin
        n_sum   = (r_op == ghb_pkg::OP_DELTA) ? (17'(h_rdata) + 17'(r_val)) : 17'(r_val);
        n_m     = signed'({3'b000, r_max_height});
        n_clamp = n_sum;
        if (n_sum < -n_m) begin
            n_clamp = -n_m;
        end else if (n_sum > n_m) begin
            n_clamp = n_m;
        end
        n_tgt = n_clamp[ghb_pkg::H_W-1:0];
        n_up  = n_clamp > 17'(h_rdata);
        n_s   = {1'b0, r_max_height, 1'b0} + 16'd10;
        n_r0  = (int'(r_row) > RADIUS_CELLS) ? CW'(int'(r_row) - RADIUS_CELLS) : '0;
        n_r1  = (int'(r_row) + RADIUS_CELLS > ROWS - 1) ? CW'(ROWS - 1)
              : CW'(int'(r_row) + RADIUS_CELLS);
        n_c0  = (int'(r_col) > RADIUS_CELLS) ? KW'(int'(r_col) - RADIUS_CELLS) : '0;
        n_c1  = (int'(r_col) + RADIUS_CELLS > COLS - 1) ? KW'(COLS - 1)
              : KW'(int'(r_col) + RADIUS_CELLS);
    end

    // height ram write: clearing pass, direct write, or brush write back
    always_comb begin
        h_we    = 1'b0;
        h_waddr = cell_waddr;
        h_wdata = cell_wdata;
        if (r_state == S_CLEAR) begin
            h_we    = (r_clr != CLR_W'(DEPTH));
            h_waddr = r_clr[HAW-1:0];
            h_wdata = '0;
        end else if (in_fire && in_bounds && (i_in.op == ghb_pkg::OP_WRITE)) begin
            h_we    = 1'b1;
            h_waddr = in_addr;
            h_wdata = i_in.value;
        end else begin
            h_we    = cell_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_height <= ghb_pkg::MAXH_RESET;
        end else if (i_cfg_we) begin
            r_max_height <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == S_SCAN) && in_circle;
            // the done state reloads the result register itself
            if (o_out.valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr != CLR_W'(DEPTH)) begin
                        r_clr <= r_clr + 1'b1;
                    end else if (w_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op  <= i_in.op;
                        r_row <= i_in.row;
                        r_col <= i_in.column;
                        r_val <= i_in.value;
                        if (!in_bounds) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (i_in.op == ghb_pkg::OP_WRITE) begin
                            r_res   <= i_in.value;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CENTER;
                        end
                    end
                end
                S_CENTER: begin
                    if (r_op == ghb_pkg::OP_READ) begin
                        r_res   <= h_rdata;
                        r_state <= S_DONE;
                    end else begin
                        r_res     <= n_tgt;
                        r_ctl.tgt <= n_tgt;
                        r_ctl.up  <= n_up;
                        r_ctl.s   <= n_s;
                        r_r       <= n_r0;
                        r_r1      <= n_r1;
                        r_c       <= n_c0;
                        r_c0      <= n_c0;
                        r_c1      <= n_c1;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_p1_addr  <= scan_addr;
                    if (r_c == r_c1) begin
                        r_c <= r_c0;
                        if (r_r == r_r1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_r <= r_r + 1'b1;
                        end
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_valid && !cell_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_height <= r_res;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.height = r_out_height;

    ghb_ram #(
        .WIDTH (ghb_pkg::H_W),
        .DEPTH (DEPTH)
    ) u_hram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata_u)
    );

    ghb_weight #(
        .RADIUS_CELLS (RADIUS_CELLS)
    ) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (d2[WAW-1:0]),
        .o_rdata (w_rdata),
        .o_ready (w_ready)
    );

    ghb_cell_update #(
        .AW (HAW)
    ) u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p1_valid),
        .i_addr  (r_p1_addr),
        .i_cur   (h_rdata),
        .i_w     (w_rdata),
        .i_ctl   (r_ctl),
        .o_we    (cell_we),
        .o_waddr (cell_waddr),
        .o_wdata (cell_wdata),
        .o_busy  (cell_busy)
    );

    // words are only taken once the weight table is filled
    `ASSERT_CLK(a_ready_after_fill, i_clk, i_rst_n, i_in.ready |-> w_ready,
                "word taken before weight fill")
    // a brush never reads a cell that is being written back in the same cycle
    `ASSERT_NEVER(a_no_rw_overlap, i_clk, i_rst_n,
                  (r_state == S_SCAN) && cell_we && (h_raddr == cell_waddr),
                  "brush read hits pending write")
    // the result is loaded only after the cell pipeline has drained
    `ASSERT_NEVER(a_done_drained, i_clk, i_rst_n,
                  (r_state == S_DONE) && (r_p1_valid || cell_busy),
                  "result before brush drained")
    // cell write backs only come from a brush in flight
    `ASSERT_CLK(a_write_in_brush, i_clk, i_rst_n,
                cell_we |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)),
                "cell write outside brush")

endmodule
